### rtl/grg_pkg.sv
package grg_pkg;

  localparam int unsigned InW   = 32;
  localparam int unsigned SqW   = 64;
  localparam int unsigned RootW = 32;
  localparam int unsigned RW    = 33;
  localparam int unsigned CsW   = 32;
  localparam int unsigned ZW    = 32;
  localparam int unsigned FracCs = 30;
  localparam int unsigned DivNumW = 64;
  localparam int unsigned QW = 34;

  typedef enum logic [1:0] {
    CaseBZero = 2'd0,
    CaseAZero = 2'd1,
    CaseGen   = 2'd2
  } case_e;

  typedef struct packed {
    case_e     kind;
    logic      a_big;
    logic      neg_r;
    logic      neg_c;
    logic      neg_s;
    logic [InW-1:0] a_raw;
    logic [InW-1:0] b_raw;
  } side_t;

endpackage

### rtl/grg_sqrt_stage.sv
// One step of the restoring square root: two radicand bits per step.
module grg_sqrt_stage (
  input  logic [grg_pkg::SqW-1:0]   rem_i,
  input  logic [grg_pkg::RootW:0]   res_i,
  input  logic [grg_pkg::SqW-1:0]   rad_i,
  output logic [grg_pkg::SqW-1:0]   rem_o,
  output logic [grg_pkg::RootW:0]   res_o,
  output logic [grg_pkg::SqW-1:0]   rad_o
);
  import grg_pkg::*;
  logic [SqW+1:0] trial;
  logic [SqW+1:0] rem_sh;
  always_comb begin
    rem_sh = {rem_i, rad_i[SqW-1 -: 2]};
    trial  = {{(SqW-RootW-1){1'b0}}, res_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_o = SqW'(rem_sh - trial);
      res_o = {res_i[RootW-1:0], 1'b1};
    end else begin
      rem_o = SqW'(rem_sh);
      res_o = {res_i[RootW-1:0], 1'b0};
    end
    rad_o = {rad_i[SqW-3:0], 2'b00};
  end
endmodule

### rtl/grg_div_stage.sv
// One step of restoring division: one quotient bit.
module grg_div_stage #(
  parameter int unsigned DW = 34
) (
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic          nbit_i,
  output logic [DW-1:0] rem_o,
  output logic          q_o
);
  logic [DW:0] sh;
  always_comb begin
    sh = {rem_i, nbit_i};
    if (sh >= {1'b0, den_i}) begin
      rem_o = DW'(sh - {1'b0, den_i});
      q_o   = 1'b1;
    end else begin
      rem_o = DW'(sh);
      q_o   = 1'b0;
    end
  end
endmodule

### rtl/givens_rotation_generator_unit.sv
// Channel  | direction | payload                           | handshake
// ---------+-----------+-----------------------------------+------------------
// input    | in        | a_in_i, b_in_i                    | in_valid_i/in_ready_o
// result   | out       | r_out_o, cos_out_o, sin_out_o,    | out_valid_o/out_ready_i
//          |           | z_out_o                           |
//
// One item may enter every cycle while the output is not stalled; the stages are
// 1 square + 8 root + 8 c/s divide + 8 reciprocal + 1 output register.
// The depth is set by the bit-serial root and dividers, a few bits a stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// The whole pipe advances together: a stalled output holds every stage and
// in_ready_o drops only when the last stage is full and not taken.
module givens_rotation_generator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [grg_pkg::InW-1:0] a_in_i,
  input  logic signed [grg_pkg::InW-1:0] b_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [grg_pkg::RW-1:0]  r_out_o,
  output logic signed [grg_pkg::CsW-1:0] cos_out_o,
  output logic signed [grg_pkg::CsW-1:0] sin_out_o,
  output logic signed [grg_pkg::ZW-1:0]  z_out_o
);
  import grg_pkg::*;

  localparam int unsigned SqSt  = 8;   // root stages, 4 bits each
  localparam int unsigned SqPer = 4;
  localparam int unsigned DvSt  = 8;   // c/s divide stages
  localparam int unsigned DvPer = 4;   // 32 quotient bits
  localparam int unsigned ZSt   = 8;
  localparam int unsigned ZPer  = 6;   // 48 quotient bits for 2^46/|c|
  localparam int unsigned ZDW   = 32;

  // Advance the whole pipe unless the output holds a result nobody takes.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- stage 0: magnitudes, squares, case decode
  logic [InW:0] ma, mb;
  side_t        sd0_d;
  always_comb begin
    ma = a_in_i[InW-1] ? (InW+1)'(-{a_in_i[InW-1], a_in_i}) : {1'b0, a_in_i};
    mb = b_in_i[InW-1] ? (InW+1)'(-{b_in_i[InW-1], b_in_i}) : {1'b0, b_in_i};
    sd0_d.a_raw = a_in_i;
    sd0_d.b_raw = b_in_i;
    sd0_d.a_big = ma > mb;
    sd0_d.neg_r = (ma > mb) ? a_in_i[InW-1] : b_in_i[InW-1];
    sd0_d.neg_c = a_in_i[InW-1] != sd0_d.neg_r;
    sd0_d.neg_s = b_in_i[InW-1] != sd0_d.neg_r;
    if (mb == '0)      sd0_d.kind = CaseBZero;
    else if (ma == '0) sd0_d.kind = CaseAZero;
    else               sd0_d.kind = CaseGen;
  end

  logic             v0_q;
  side_t            sd0_q;
  logic [SqW-1:0]   sqa_q, sqb_q;
  logic [InW:0]     ma0_q, mb0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd0_q <= sd0_d;
      ma0_q <= ma;
      mb0_q <= mb;
      sqa_q <= SqW'(ma * ma);
      sqb_q <= SqW'(mb * mb);
    end
  end

  // ---------------- root pipeline
  logic [SqSt:0]            sv_q;
  side_t                    ssd_q  [SqSt+1];
  logic [SqW-1:0]           srem_q [SqSt+1];
  logic [RootW:0]           sres_q [SqSt+1];
  logic [SqW-1:0]           srad_q [SqSt+1];
  logic [InW:0]             sma_q  [SqSt+1];
  logic [InW:0]             smb_q  [SqSt+1];

  // entry slot 0 is combinational from the square registers
  assign sv_q[0]   = v0_q;
  assign ssd_q[0]  = sd0_q;
  assign srem_q[0] = '0;
  assign sres_q[0] = '0;
  assign srad_q[0] = SqW'(sqa_q + sqb_q);
  assign sma_q[0]  = ma0_q;
  assign smb_q[0]  = mb0_q;

  for (genvar g = 0; g < SqSt; g++) begin : g_root
    logic [SqW-1:0] rem_w [SqPer+1];
    logic [RootW:0] res_w [SqPer+1];
    logic [SqW-1:0] rad_w [SqPer+1];
    assign rem_w[0] = srem_q[g];
    assign res_w[0] = sres_q[g];
    assign rad_w[0] = srad_q[g];
    for (genvar k = 0; k < SqPer; k++) begin : g_step
      grg_sqrt_stage u_step (
        .rem_i(rem_w[k]), .res_i(res_w[k]), .rad_i(rad_w[k]),
        .rem_o(rem_w[k+1]), .res_o(res_w[k+1]), .rad_o(rad_w[k+1])
      );
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[g+1] <= 1'b0;
      else if (adv) sv_q[g+1] <= sv_q[g];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ssd_q[g+1]  <= ssd_q[g];
        srem_q[g+1] <= rem_w[SqPer];
        sres_q[g+1] <= res_w[SqPer];
        srad_q[g+1] <= rad_w[SqPer];
        sma_q[g+1]  <= sma_q[g];
        smb_q[g+1]  <= smb_q[g];
      end
    end
  end

  // round to nearest: remainder above root means bump
  logic [RootW:0] mag_w;
  assign mag_w = (SqW'(srem_q[SqSt]) > SqW'(sres_q[SqSt]))
               ? sres_q[SqSt] + 1'b1 : sres_q[SqSt];

  // ---------------- c/s divide pipeline, rounded by adding den/2 to numerator
  // numerator (m<<30)+mag/2 fits 63 bits; quotient <= 2^30 so 32 bits suffice,
  // so start with a remainder preloaded with the top 31 numerator bits.
  localparam int unsigned NumW = 63;
  localparam int unsigned QBits = DvSt * DvPer;   // 32
  localparam int unsigned PreW = NumW - QBits;    // 31

  logic [DvSt:0]  dv_q;
  side_t          dsd_q [DvSt+1];
  logic [QW-1:0]  dden_q [DvSt+1];
  logic [QW-1:0]  drc_q  [DvSt+1];
  logic [QW-1:0]  drs_q  [DvSt+1];
  logic [QBits-1:0] dnc_q [DvSt+1];
  logic [QBits-1:0] dns_q [DvSt+1];
  logic [QBits-1:0] dqc_q [DvSt+1];
  logic [QBits-1:0] dqs_q [DvSt+1];

  logic [NumW-1:0] numc_w, nums_w;
  assign numc_w = NumW'({sma_q[SqSt], 30'b0}) + NumW'(mag_w[RootW:1]);
  assign nums_w = NumW'({smb_q[SqSt], 30'b0}) + NumW'(mag_w[RootW:1]);

  assign dv_q[0]   = sv_q[SqSt];
  assign dsd_q[0]  = ssd_q[SqSt];
  assign dden_q[0] = QW'(mag_w);
  assign drc_q[0]  = QW'(numc_w[NumW-1 -: PreW]);
  assign drs_q[0]  = QW'(nums_w[NumW-1 -: PreW]);
  assign dnc_q[0]  = numc_w[QBits-1:0];
  assign dns_q[0]  = nums_w[QBits-1:0];
  assign dqc_q[0]  = '0;
  assign dqs_q[0]  = '0;
  logic [RootW:0] dmag_q [DvSt+1];
  assign dmag_q[0] = mag_w;

  for (genvar g = 0; g < DvSt; g++) begin : g_div
    logic [QW-1:0] rc [DvPer+1];
    logic [QW-1:0] rs [DvPer+1];
    logic [DvPer-1:0] qc, qs;
    assign rc[0] = drc_q[g];
    assign rs[0] = drs_q[g];
    for (genvar k = 0; k < DvPer; k++) begin : g_step
      grg_div_stage #(.DW(QW)) u_c (
        .rem_i(rc[k]), .den_i(dden_q[g]), .nbit_i(dnc_q[g][QBits-1-k]),
        .rem_o(rc[k+1]), .q_o(qc[DvPer-1-k])
      );
      grg_div_stage #(.DW(QW)) u_s (
        .rem_i(rs[k]), .den_i(dden_q[g]), .nbit_i(dns_q[g][QBits-1-k]),
        .rem_o(rs[k+1]), .q_o(qs[DvPer-1-k])
      );
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[g+1] <= 1'b0;
      else if (adv) dv_q[g+1] <= dv_q[g];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dsd_q[g+1]  <= dsd_q[g];
        dden_q[g+1] <= dden_q[g];
        dmag_q[g+1] <= dmag_q[g];
        drc_q[g+1]  <= rc[DvPer];
        drs_q[g+1]  <= rs[DvPer];
        dnc_q[g+1]  <= {dnc_q[g][QBits-DvPer-1:0], {DvPer{1'b0}}};
        dns_q[g+1]  <= {dns_q[g][QBits-DvPer-1:0], {DvPer{1'b0}}};
        dqc_q[g+1]  <= {dqc_q[g][QBits-DvPer-1:0], qc};
        dqs_q[g+1]  <= {dqs_q[g][QBits-DvPer-1:0], qs};
      end
    end
  end

  // ---------------- reciprocal pipeline: round(2^46/|c|), saturating
  // numerator 2^46 + mc/2 (47 bits); quotient bits needed: 48 cover it.
  localparam int unsigned ZQB = ZSt * ZPer;  // 48
  logic [ZSt:0]   zv_q;
  side_t          zsd_q [ZSt+1];
  logic [CsW-1:0] zmc_q [ZSt+1];
  logic [CsW-1:0] zms_q [ZSt+1];
  logic [RootW:0] zmag_q [ZSt+1];
  logic [ZDW:0]   zr_q  [ZSt+1];
  logic [ZQB-1:0] zn_q  [ZSt+1];
  logic [ZQB-1:0] zq_q  [ZSt+1];

  assign zv_q[0]   = dv_q[DvSt];
  assign zsd_q[0]  = dsd_q[DvSt];
  assign zmc_q[0]  = dqc_q[DvSt];
  assign zms_q[0]  = dqs_q[DvSt];
  assign zmag_q[0] = dmag_q[DvSt];
  assign zr_q[0]   = '0;
  assign zn_q[0]   = ZQB'(64'd1 << 46) + ZQB'(dqc_q[DvSt][CsW-1:1]);
  assign zq_q[0]   = '0;

  for (genvar g = 0; g < ZSt; g++) begin : g_rcp
    logic [ZDW:0] rz [ZPer+1];
    logic [ZPer-1:0] qz;
    assign rz[0] = zr_q[g];
    for (genvar k = 0; k < ZPer; k++) begin : g_step
      grg_div_stage #(.DW(ZDW+1)) u_z (
        .rem_i(rz[k]), .den_i({1'b0, zmc_q[g]}), .nbit_i(zn_q[g][ZQB-1-k]),
        .rem_o(rz[k+1]), .q_o(qz[ZPer-1-k])
      );
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) zv_q[g+1] <= 1'b0;
      else if (adv) zv_q[g+1] <= zv_q[g];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        zsd_q[g+1]  <= zsd_q[g];
        zmc_q[g+1]  <= zmc_q[g];
        zms_q[g+1]  <= zms_q[g];
        zmag_q[g+1] <= zmag_q[g];
        zr_q[g+1]   <= rz[ZPer];
        zn_q[g+1]   <= {zn_q[g][ZQB-ZPer-1:0], {ZPer{1'b0}}};
        zq_q[g+1]   <= {zq_q[g][ZQB-ZPer-1:0], qz};
      end
    end
  end

  // ---------------- output assembly
  side_t          fs;
  logic [CsW-1:0] fmc, fms;
  logic [ZQB-1:0] fzq;
  logic [RootW:0] fmag;
  logic [RW-1:0]  r_d;
  logic [CsW-1:0] c_d, s_d;
  logic [ZW-1:0]  z_d;
  logic [CsW-1:0] mz_s;

  always_comb begin
    fs   = zsd_q[ZSt];
    fmc  = zmc_q[ZSt];
    fms  = zms_q[ZSt];
    fzq  = zq_q[ZSt];
    fmag = zmag_q[ZSt];
    mz_s = (fms + CsW'(8192)) >> 14;
    r_d = '0; c_d = '0; s_d = '0; z_d = '0;
    unique case (fs.kind)
      CaseBZero: begin
        r_d = RW'($signed(fs.a_raw));
        c_d = CsW'(1) << FracCs;
        s_d = '0;
        z_d = '0;
      end
      CaseAZero: begin
        r_d = RW'($signed(fs.b_raw));
        c_d = '0;
        s_d = CsW'(1) << FracCs;
        z_d = ZW'(1) << 16;
      end
      CaseGen: begin
        r_d = fs.neg_r ? RW'(-{1'b0, fmag}) : RW'({1'b0, fmag});
        c_d = fs.neg_c ? -fmc : fmc;
        s_d = fs.neg_s ? -fms : fms;
        if (fs.a_big) begin
          z_d = fs.neg_s ? ZW'(-mz_s) : ZW'(mz_s);
        end else if (fmc != '0) begin
          if (fs.neg_c) begin
            z_d = (fzq > ZQB'(32'h8000_0000)) ? ZW'(32'h8000_0000)
                                               : ZW'(-fzq);
          end else begin
            z_d = (fzq > ZQB'(32'h7FFF_FFFF)) ? ZW'(32'h7FFF_FFFF)
                                               : ZW'(fzq);
          end
        end else begin
          z_d = ZW'(1) << 16;
        end
      end
      default: begin
        r_d = '0;
      end
    endcase
  end

  logic out_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= zv_q[ZSt];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_out_o   <= r_d;
      cos_out_o <= c_d;
      sin_out_o <= s_d;
      z_out_o   <= z_d;
    end
  end
  assign out_valid_o = out_v_q;

  // A held result must keep r_out_o and z_out_o stable.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(r_out_o) && $stable(z_out_o))
    else $error("result changed while held");
  // Stall on the output must back-pressure the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken during stall");
  // Cosine magnitude never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(cos_out_o) <= $signed(32'sh4000_0000)) &&
                    ($signed(cos_out_o) >= -$signed(32'sh4000_0000)))
    else $error("cosine out of range");

endmodule
